FILE: sv/sark_pkg.sv
package sark_pkg;

  // Field widths fixed by the block's interface.
  localparam int INDEX_W     = 6;
  localparam int VALUE_W     = 32;
  localparam int COUNT_W     = 7;
  localparam int CFG_INDEX_W = 2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_BASE = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIZE = 2'd1;

  // Search token that travels down the chain one cell per cycle.
  typedef struct packed {
    logic               active;
    logic               found;
    logic [INDEX_W-1:0] want;
    logic [INDEX_W-1:0] offset;
  } token_t;

  // Refill command broadcast to every cell.
  typedef struct packed {
    logic               load;
    logic [COUNT_W-1:0] fill_n;
  } fill_t;

endpackage

FILE: sv/sark_in_if.sv
interface sark_in_if;
  logic                        valid;
  logic                        ready;
  logic [sark_pkg::INDEX_W-1:0] index;

  modport source (output valid, output index, input ready);
  modport sink   (input valid, input index, output ready);
endinterface

FILE: sv/sark_out_if.sv
interface sark_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [sark_pkg::VALUE_W-1:0] value;
  logic                               bad_index;
  logic [sark_pkg::COUNT_W-1:0]        remaining;

  modport source (output valid, output value, output bad_index, output remaining, input ready);
  modport sink   (input valid, input value, input bad_index, input remaining, output ready);
endinterface

FILE: sv/sark_cell.sv
module sark_cell #(
  parameter int K = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  sark_pkg::fill_t  fill,
  input  sark_pkg::token_t tok_in,
  output sark_pkg::token_t tok_out
);

  logic             present;
  logic             hit;
  sark_pkg::token_t tok_next;

  // A live token stops at the first present element once its countdown is zero;
  // every present element it passes before that uses up one count.
  always_comb begin
    tok_next = tok_in;
    hit      = 1'b0;
    if (tok_in.active && !tok_in.found && present) begin
      if (tok_in.want == '0) begin
        hit             = 1'b1;
        tok_next.found  = 1'b1;
        tok_next.offset = sark_pkg::INDEX_W'(K);
      end else begin
        tok_next.want = tok_in.want - 1'b1;
      end
    end
  end

  // Presence bit of the element at this offset.
  always_ff @(posedge clk) begin
    if (rst) begin
      present <= 1'b1;
    end else if (fill.load) begin
      present <= (sark_pkg::COUNT_W'(K) < fill.fill_n);
    end else if (hit) begin
      present <= 1'b0;
    end
  end

  // Hand the token to the next cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out        <= '0;
    end else begin
      tok_out        <= tok_next;
    end
  end

endmodule

FILE: sv/select_and_remove_kth_remaining.sv
// Removes and returns the element at a given position among those still present in a set
// of MAX_ELEMENTS or fewer consecutive integers starting at base_value. The set is held as
// a chain of one-bit cells, one per offset, and a search token walks the chain one cell per
// cycle; a valid index is answered once the token has passed the last cell, and an index
// at or beyond the remaining count is answered from idle with bad_index set, value 0 and
// no change to the set. One transaction is in flight at a time, and the next is accepted
// in the cycle after the result is taken. Reset, and any write to base_value or set_size,
// refills the set at once with min(set_size, MAX_ELEMENTS) elements.
module select_and_remove_kth_remaining #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [sark_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [sark_pkg::VALUE_W-1:0]         cfg_data,
  sark_in_if.sink                              in_ch,
  sark_out_if.source                           out_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [sark_pkg::COUNT_W-1:0] MAX_N = sark_pkg::COUNT_W'(MAX_ELEMENTS);

  logic [1:0]                           state;
  logic signed [sark_pkg::VALUE_W-1:0]  base_value;
  logic [sark_pkg::COUNT_W-1:0]         set_size;
  logic [sark_pkg::COUNT_W-1:0]         count;
  logic signed [sark_pkg::VALUE_W-1:0]  out_value;
  logic                                 out_bad;
  logic [sark_pkg::COUNT_W-1:0]         out_remaining;

  logic                                 in_acc;
  logic                                 out_acc;
  logic                                 idx_bad;
  logic                                 cfg_hit;
  logic [sark_pkg::COUNT_W-1:0]         size_new;
  sark_pkg::fill_t                      fill;
  sark_pkg::token_t                     tok_chain [MAX_ELEMENTS+1];
  sark_pkg::token_t                     tok_last;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_ch.valid && out_ch.ready;
  assign idx_bad = ({1'b0, in_ch.index} >= count);

  // Refill size after a configuration write, saturated to the chain length.
  assign cfg_hit  = cfg_we && ((cfg_index == sark_pkg::CFG_BASE) ||
                               (cfg_index == sark_pkg::CFG_SIZE));
  assign size_new = (cfg_index == sark_pkg::CFG_SIZE) ?
                    cfg_data[sark_pkg::COUNT_W-1:0] : set_size;
  assign fill.load   = cfg_hit;
  assign fill.fill_n = (size_new > MAX_N) ? MAX_N : size_new;

  // A token enters the chain only for an index that is known to hit.
  always_comb begin
    tok_chain[0].active = in_acc && !idx_bad;
    tok_chain[0].found  = 1'b0;
    tok_chain[0].want   = in_ch.index;
    tok_chain[0].offset = '0;
  end

  for (genvar k = 0; k < MAX_ELEMENTS; k++) begin : g_cell
    sark_cell #(
      .K (k)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .fill    (fill),
      .tok_in  (tok_chain[k]),
      .tok_out (tok_chain[k+1])
    );
  end

  assign tok_last = tok_chain[MAX_ELEMENTS];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      base_value <= '0;
      set_size   <= 7'd64;
    end else if (cfg_we) begin
      if (cfg_index == sark_pkg::CFG_BASE) begin
        base_value <= cfg_data;
      end
      if (cfg_index == sark_pkg::CFG_SIZE) begin
        set_size <= cfg_data[sark_pkg::COUNT_W-1:0];
      end
    end
  end

  // Sequencer, remaining count and result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      count <= MAX_N;
    end else begin
      if (cfg_hit) begin
        count <= fill.fill_n;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            if (idx_bad) begin
              out_value     <= '0;
              out_bad       <= 1'b1;
              out_remaining <= count;
              state         <= ST_DONE;
            end else begin
              state <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (tok_last.active) begin
            if (tok_last.found) begin
              out_value     <= base_value + sark_pkg::VALUE_W'(tok_last.offset);
              out_bad       <= 1'b0;
              out_remaining <= count - 1'b1;
              count         <= count - 1'b1;
            end else begin
              out_value     <= '0;
              out_bad       <= 1'b1;
              out_remaining <= count;
            end
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_acc) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready      = (state == ST_IDLE);
  assign out_ch.valid     = (state == ST_DONE);
  assign out_ch.value     = out_value;
  assign out_ch.bad_index = out_bad;
  assign out_ch.remaining = out_remaining;

endmodule

FILE: verif/select_and_remove_kth_remaining_tb.sv
module select_and_remove_kth_remaining_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_ELEMENTS = 64;

  // Register indexes that decode to nothing.
  localparam logic [sark_pkg::CFG_INDEX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [sark_pkg::CFG_INDEX_W-1:0] CFG_SPARE_B = 2'd3;

  // One predicted result of a removal request.
  typedef struct {
    logic signed [sark_pkg::VALUE_W-1:0] value;
    logic                                bad_index;
    logic [sark_pkg::COUNT_W-1:0]        remaining;
  } removal_t;

  // Tracks the presence bitmap and the queue of removals still to come out.
  class removal_scoreboard;
    logic signed [sark_pkg::VALUE_W-1:0] base_value;
    logic [sark_pkg::COUNT_W-1:0]        set_size;
    logic [63:0]                         present;
    logic [sark_pkg::COUNT_W-1:0]        count;
    removal_t                            pending[$];
    int                                  errors;
    int                                  n_results;
    int                                  n_removed;
    int                                  n_bad;
    int                                  n_writes;

    function new();
      base_value = '0;
      set_size   = 7'd64;
      errors     = 0;
      n_results  = 0;
      n_removed  = 0;
      n_bad      = 0;
      n_writes   = 0;
      refill();
    endfunction

    // Every element of the configured range becomes present again.
    function void refill();
      int n;
      n = (set_size > MAX_ELEMENTS) ? MAX_ELEMENTS : int'(set_size);
      present = (n >= 64) ? '1 : ((64'd1 << n) - 64'd1);
      count   = sark_pkg::COUNT_W'(n);
    endfunction

    function void write_register(logic [sark_pkg::CFG_INDEX_W-1:0] idx,
                                 logic [sark_pkg::VALUE_W-1:0] data);
      n_writes++;
      case (idx)
        sark_pkg::CFG_BASE: begin
          base_value = data;
          refill();
        end
        sark_pkg::CFG_SIZE: begin
          set_size = data[sark_pkg::COUNT_W-1:0];
          refill();
        end
        default: ;
      endcase
    endfunction

    // Removes the idx-th present element, or flags the request as out of range.
    function void note_index(logic [sark_pkg::INDEX_W-1:0] idx);
      removal_t r;
      int       seen;
      bit       done;
      r.value     = '0;
      r.bad_index = 1'b1;
      r.remaining = count;
      seen        = 0;
      done        = 0;
      if (idx < count) begin
        for (int k = 0; k < MAX_ELEMENTS; k++) begin
          if (!done && present[k]) begin
            if (seen == int'(idx)) begin
              present[k]  = 1'b0;
              count       = count - 1'b1;
              r.value     = base_value + sark_pkg::VALUE_W'(k);
              r.bad_index = 1'b0;
              r.remaining = count;
              done        = 1;
            end
            seen++;
          end
        end
      end
      pending.push_back(r);
    endfunction

    function void check_result(logic signed [sark_pkg::VALUE_W-1:0] value, logic bad_index,
                               logic [sark_pkg::COUNT_W-1:0] remaining);
      removal_t r;
      n_results++;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t: unexpected result value=%0d bad_index=%0b remaining=%0d",
                 $time, value, bad_index, remaining);
        return;
      end
      r = pending.pop_front();
      if (r.bad_index) n_bad++;
      else n_removed++;
      if (value !== r.value) begin
        errors++;
        $display("%0t: value mismatch: expected %0d, actual %0d", $time, r.value, value);
      end
      if (bad_index !== r.bad_index) begin
        errors++;
        $display("%0t: bad_index mismatch: expected %0b, actual %0b",
                 $time, r.bad_index, bad_index);
      end
      if (remaining !== r.remaining) begin
        errors++;
        $display("%0t: remaining mismatch: expected %0d, actual %0d",
                 $time, r.remaining, remaining);
      end
    endfunction
  endclass

  logic                             clk = 1'b0;
  logic                             rst;
  logic                             cfg_we;
  logic [sark_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [sark_pkg::VALUE_W-1:0]     cfg_data;

  sark_in_if  in_ch();
  sark_out_if out_ch();

  removal_scoreboard sb = new();

  // Shared traffic controls: steady turns idling off on both sides.
  bit steady;
  int hold_off_cycles;
  int random_items;
  int n_settings;

  select_and_remove_kth_remaining #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watch both channels at the rising edge.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_ch.valid && out_ch.ready) begin
        sb.check_result(out_ch.value, out_ch.bad_index, out_ch.remaining);
      end
      if (in_ch.valid && in_ch.ready) begin
        sb.note_index(in_ch.index);
      end
    end
  end

  // Result side: random back-pressure, always ready when steady, or a long hold-off when requested.
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_cycles > 0) begin
        out_ch.ready <= 1'b0;
        hold_off_cycles--;
      end else if (steady) begin
        out_ch.ready <= 1'b1;
      end else begin
        out_ch.ready <= ($urandom_range(99, 0) >= 14);
      end
    end
  end

  // Offers one request; a random index is chosen once the predictor is up to date.
  task automatic offer_index(input bit use_fixed,
                             input logic [sark_pkg::INDEX_W-1:0] fixed_idx,
                             input int valid_pct);
    logic [sark_pkg::INDEX_W-1:0] idx;
    @(negedge clk);
    if (use_fixed) begin
      idx = fixed_idx;
    end else if (sb.count > 0 && $urandom_range(99, 0) < valid_pct) begin
      idx = sark_pkg::INDEX_W'($urandom_range(int'(sb.count) - 1, 0));
    end else begin
      idx = sark_pkg::INDEX_W'($urandom_range(63, 0));
    end
    while (!steady && $urandom_range(99, 0) < 14) begin
      in_ch.valid <= 1'b0;
      in_ch.index <= sark_pkg::INDEX_W'($urandom);
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.index <= idx;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Drops valid and waits until every outstanding removal has come back.
  task automatic wait_for_results(input int extra);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (sb.pending.size() != 0) @(negedge clk);
    repeat (extra) @(negedge clk);
  endtask

  task automatic write_register(input logic [sark_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [sark_pkg::VALUE_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    sb.write_register(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // One random setting followed by a drain of the set, mostly with in-range indexes.
  task automatic random_phase(input int phase_no);
    logic [sark_pkg::VALUE_W-1:0] base;
    logic [sark_pkg::VALUE_W-1:0] size;
    int                           n_items;
    int                           sel;
    wait_for_results(4);
    sel = $urandom_range(9, 0);
    case (sel)
      0: base = 32'h8000_0000;
      1: base = 32'h7FFF_FFFF;
      2: base = 32'h0;
      3: base = 32'hFFFF_FFF0;
      default: base = $urandom;
    endcase
    sel = $urandom_range(19, 0);
    if (sel == 0) size = 32'd0;
    else if (sel < 3) size = 32'd64;
    else if (sel < 5) size = {$urandom_range(0, 1) ? 25'h1FF_FFFF : 25'h0,
                              7'($urandom_range(127, 65))};
    else size = 32'($urandom_range(64, 1)) | ($urandom & 32'hFFFF_FF80);
    case ($urandom_range(3, 0))
      0: begin
        write_register(sark_pkg::CFG_BASE, base);
        write_register(sark_pkg::CFG_SIZE, size);
      end
      1: write_register(sark_pkg::CFG_SIZE, size);
      2: write_register(sark_pkg::CFG_BASE, base);
      default: begin
        write_register($urandom_range(1, 0) ? CFG_SPARE_A : CFG_SPARE_B, $urandom);
        write_register(sark_pkg::CFG_SIZE, size);
      end
    endcase
    // The pressure phases always run on a full set so that they last long enough.
    if (phase_no == 3 || phase_no == 5 || phase_no == 7) begin
      write_register(sark_pkg::CFG_SIZE, 32'd64);
    end
    n_settings++;
    steady  = (phase_no == 3);
    n_items = int'(sb.count) + $urandom_range(4, 0);
    for (int i = 0; i < n_items; i++) begin
      if (phase_no == 5 && i == 2) hold_off_cycles = 400;
      if (phase_no == 7 && i == n_items / 2) wait_for_results(0);
      offer_index(1'b0, '0, 88);
      random_items++;
    end
    steady = 1'b0;
  endtask

  // Directed requests, then random settings until the item budget is used up.
  initial begin
    int phase_no;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_index       = sark_pkg::CFG_BASE;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.index     = '0;
    steady          = 1'b0;
    hold_off_cycles = 0;
    random_items    = 0;
    n_settings      = 1;
    repeat (10) @(negedge clk);
    rst <= 1'b0;

    // Full default set: top and bottom positions, out-of-range by one, bit patterns.
    offer_index(1'b1, 6'd63, 0);
    offer_index(1'b1, 6'd63, 0);
    offer_index(1'b1, 6'd0, 0);
    offer_index(1'b1, 6'd62, 0);
    offer_index(1'b1, 6'd61, 0);
    offer_index(1'b1, 6'd31, 0);
    offer_index(1'b1, 6'b101010, 0);
    offer_index(1'b1, 6'b010101, 0);

    // Values that wrap past the top of the signed range, then an emptied set.
    wait_for_results(4);
    write_register(sark_pkg::CFG_BASE, 32'h7FFF_FFFE);
    write_register(sark_pkg::CFG_SIZE, 32'd3);
    offer_index(1'b1, 6'd2, 0);
    offer_index(1'b1, 6'd1, 0);
    offer_index(1'b1, 6'd0, 0);
    offer_index(1'b1, 6'd0, 0);
    offer_index(1'b1, 6'd63, 0);

    // A set of size zero answers every request as out of range.
    wait_for_results(4);
    write_register(sark_pkg::CFG_SIZE, 32'd0);
    offer_index(1'b1, 6'd0, 0);
    offer_index(1'b1, 6'd63, 0);

    // Oversized set saturates to the full capacity.
    wait_for_results(4);
    write_register(sark_pkg::CFG_SIZE, 32'hFFFF_FFFF);
    write_register(sark_pkg::CFG_BASE, 32'h8000_0000);
    offer_index(1'b1, 6'd0, 0);
    offer_index(1'b1, 6'd62, 0);
    offer_index(1'b1, 6'd5, 0);

    // Writes to undecoded indexes leave the set as it is.
    wait_for_results(4);
    write_register(CFG_SPARE_A, 32'hFFFF_FFFF);
    write_register(CFG_SPARE_B, 32'h0000_0001);
    offer_index(1'b1, 6'd0, 0);

    // One past capacity, then a single-element set.
    wait_for_results(4);
    write_register(sark_pkg::CFG_SIZE, 32'd65);
    offer_index(1'b1, 6'd63, 0);
    wait_for_results(4);
    write_register(sark_pkg::CFG_SIZE, 32'd1);
    offer_index(1'b1, 6'd0, 0);
    offer_index(1'b1, 6'd0, 0);
    n_settings += 5;

    phase_no = 0;
    while (random_items < 1200) begin
      random_phase(phase_no);
      phase_no++;
    end

    wait_for_results(0);
    repeat (80) @(negedge clk);
    if (sb.pending.size() != 0) begin
      sb.errors++;
      $display("%0t: %0d results never arrived", $time, sb.pending.size());
    end
    $display("Checked %0d results: %0d removals and %0d out-of-range requests.",
             sb.n_results, sb.n_removed, sb.n_bad);
    $display("Ran %0d set configurations with %0d register writes, %0d random requests.",
             n_settings, sb.n_writes, random_items);
    if (sb.errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #10_000_000;
    $display("%0t: timeout with %0d results outstanding", $time, sb.pending.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

FILE: files.f
sv/sark_pkg.sv
sv/sark_in_if.sv
sv/sark_out_if.sv
sv/sark_cell.sv
sv/select_and_remove_kth_remaining.sv
verif/select_and_remove_kth_remaining_tb.sv
